### hw/rtl/lms_adaptive_fir_filter_unit_macros.svh
// Assertion macros used by the checker file of the LMS adaptive FIR filter.
`ifndef LMS_ADAPTIVE_FIR_FILTER_UNIT_MACROS_SVH
`define LMS_ADAPTIVE_FIR_FILTER_UNIT_MACROS_SVH

// Property checked at every clock edge, including while reset is held.
`define LAFIR_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked at every clock edge outside of reset.
`define LAFIR_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### hw/rtl/lafir_pkg.sv
// Package with the widths, constants and types of the LMS adaptive FIR filter.
`timescale 1ns / 1ps

package lafir_pkg;

  localparam int unsigned TAPS_DEFAULT = 32;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned ERR_W    = 17;

  // Product of a weight and a sample, exact in Q5.43.
  localparam int unsigned PROD_W = WEIGHT_W + SAMPLE_W;
  // Step size times error, 17 by 17 bits signed.
  localparam int unsigned MUERR_W = ERR_W + ERR_W;
  // Twice that product.
  localparam int unsigned GAIN_W = MUERR_W + 1;
  // Gain times a sample, exact with 46 fractional bits.
  localparam int unsigned RAW_W = GAIN_W + SAMPLE_W;
  // Weight plus rounded update before saturation.
  localparam int unsigned WSUM_W = WEIGHT_W + 3;

  localparam int unsigned OUT_SHIFT = 28;
  localparam int unsigned UPD_SHIFT = 18;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILTER,
    ST_FDRAIN,
    ST_ROUND,
    ST_GAIN,
    ST_UPDATE,
    ST_UDRAIN,
    ST_DONE
  } state_t;

  // Strobes from the sequencer to the arithmetic.
  typedef struct packed {
    logic load_item;    // take in the desired sample, clear the accumulator
    logic data_valid;   // memory read data of one tap is present
    logic sample_live;  // that tap holds a sample since the last clear
    logic acc_add;      // add the registered product into the accumulator
    logic round_en;     // round and saturate the output, form the error
    logic gain_en;      // form twice step size times error
    logic wt_clear;     // write zero weights during the clearing pass
    logic out_load;     // move the result into the output register
  } dp_ctrl_t;

endpackage

### hw/rtl/lafir_feed_if.sv
// Input channel of the LMS adaptive FIR filter: one sample pair per word.
`timescale 1ns / 1ps

interface lafir_feed_if;
  logic                                valid;
  logic                                ready;
  logic signed [lafir_pkg::SAMPLE_W-1:0] sample;
  logic signed [lafir_pkg::SAMPLE_W-1:0] desired;
  logic                                block_start;

  modport source (output valid, output sample, output desired, output block_start,
                  input ready);
  modport sink (input valid, input sample, input desired, input block_start,
                output ready);
endinterface

### hw/rtl/lafir_result_if.sv
// Output channel of the LMS adaptive FIR filter: filter output and error per word.
`timescale 1ns / 1ps

interface lafir_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lafir_pkg::SAMPLE_W-1:0] filtered;
  logic signed [lafir_pkg::ERR_W-1:0]    estimate_error;

  modport source (output valid, output filtered, output estimate_error, input ready);
  modport sink (input valid, input filtered, input estimate_error, output ready);
endinterface

### hw/rtl/lms_adaptive_fir_filter_unit.sv
// Top level of the LMS adaptive FIR filter unit.
`timescale 1ns / 1ps

// LMS adaptive FIR filter with TAPS taps in fixed point.
// The feed channel takes one word per item: a Q1.15 sample, a Q1.15 desired
// value and a block start flag, which empties the sample history (but not the
// weights) before the sample enters. The result channel returns one word per
// item: the Q1.15 filter output, computed before adaptation, and the Q2.15
// error. The step size register is written through cfg_we and cfg_wdata and
// must only change while the unit is idle.
// Samples and weights sit in two one-port-read RAMs. One multiply-accumulate
// walks all taps for the output, then one multiply and saturating add walks
// them again and writes each adapted weight back. The two passes over the
// memories set the pace: the next item can be taken only after both passes of
// the current one are done and its result has moved into the output register,
// which happens as soon as that register is free.
// A finished result waits in the output register while the receiver stalls;
// the unit accepts the next word meanwhile and holds its own result back
// until the register has been taken.
// After reset, a clearing pass writes zero into every weight; feed ready
// stays low until it is done. Reset also empties the history and loads the
// step size of 328.

module lms_adaptive_fir_filter_unit #(
  parameter int unsigned TAPS = lafir_pkg::TAPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lafir_pkg::STEP_W-1:0]  cfg_wdata,
  lafir_feed_if.sink                    feed,
  lafir_result_if.source                result
);

  localparam int unsigned IDX_W = $clog2(TAPS);

  lafir_pkg::dp_ctrl_t             ctl;
  logic                            dly_we;
  logic [IDX_W-1:0]                dly_waddr;
  logic [IDX_W-1:0]                dly_raddr;
  logic [lafir_pkg::SAMPLE_W-1:0]  dly_rdata;
  logic                            wt_we;
  logic [IDX_W-1:0]                wt_waddr;
  logic [IDX_W-1:0]                wt_raddr;
  logic [lafir_pkg::WEIGHT_W-1:0]  wt_wdata;
  logic [lafir_pkg::WEIGHT_W-1:0]  wt_rdata;

  lafir_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .feed_valid       (feed.valid),
    .feed_block_start (feed.block_start),
    .feed_ready       (feed.ready),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .ctl              (ctl),
    .dly_we           (dly_we),
    .dly_waddr        (dly_waddr),
    .dly_raddr        (dly_raddr),
    .wt_we            (wt_we),
    .wt_waddr         (wt_waddr),
    .wt_raddr         (wt_raddr)
  );

  // Circular sample history: the newest sample sits at the head pointer.
  lafir_ram #(
    .WIDTH (lafir_pkg::SAMPLE_W),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (feed.sample),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  // Tap weights in Q4.28, indexed by tap.
  lafir_ram #(
    .WIDTH (lafir_pkg::WEIGHT_W),
    .DEPTH (TAPS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  lafir_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .feed_desired   (feed.desired),
    .rd_sample      (dly_rdata),
    .rd_weight      (wt_rdata),
    .wt_wdata       (wt_wdata),
    .filtered       (result.filtered),
    .estimate_error (result.estimate_error)
  );

endmodule

### hw/rtl/lafir_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lafir_ram #(
  parameter int unsigned WIDTH = lafir_pkg::SAMPLE_W,
  parameter int unsigned DEPTH = lafir_pkg::TAPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lafir_ctrl.sv
// Sequencer of the LMS filter: state machine, tap counters and memory addressing.
`timescale 1ns / 1ps

module lafir_ctrl #(
  parameter int unsigned TAPS = lafir_pkg::TAPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     feed_valid,
  input  logic                     feed_block_start,
  output logic                     feed_ready,
  input  logic                     out_ready,
  output logic                     out_valid,
  output lafir_pkg::dp_ctrl_t      ctl,
  output logic                     dly_we,
  output logic [$clog2(TAPS)-1:0]  dly_waddr,
  output logic [$clog2(TAPS)-1:0]  dly_raddr,
  output logic                     wt_we,
  output logic [$clog2(TAPS)-1:0]  wt_waddr,
  output logic [$clog2(TAPS)-1:0]  wt_raddr
);

  localparam int unsigned IDX_W = $clog2(TAPS);
  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(TAPS);
  localparam logic [CNT_W-1:0] FILL_ONE = CNT_W'(1);

  lafir_pkg::state_t state, state_next;

  logic [IDX_W-1:0] k;         // tap index of the read being issued
  logic [IDX_W-1:0] addr;      // delay line address of that tap
  logic [IDX_W-1:0] head;      // delay line address of the newest sample
  logic [IDX_W-1:0] head_new;
  logic [CNT_W-1:0] fill;      // samples held since the last clear
  logic             v1, v2;    // read data present, product present
  logic             live1;
  logic [IDX_W-1:0] k1, k2;
  logic             issue;
  logic             accept;
  logic             upd_pass;

  assign head_new = (head == '0) ? LAST : head - IDX_W'(1);
  assign accept   = feed_valid && feed_ready;
  assign upd_pass = (state == lafir_pkg::ST_UPDATE) || (state == lafir_pkg::ST_UDRAIN);

  assign dly_waddr = head_new;
  assign dly_raddr = addr;
  assign wt_raddr  = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lafir_pkg::ST_CLEAR;
      k         <= '0;
      head      <= '0;
      fill      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (issue || state == lafir_pkg::ST_CLEAR) begin
        k <= (k == LAST) ? '0 : k + IDX_W'(1);
      end else begin
        k <= '0;
      end
      if (accept) begin
        head <= head_new;
        if (feed_block_start) begin
          fill <= FILL_ONE;
        end else if (fill != FILL_FULL) begin
          fill <= fill + FILL_ONE;
        end
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Address and pipeline tags need no reset: they only matter under v1 and v2.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr <= head_new;
    end else if (issue) begin
      addr <= (addr == LAST) ? '0 : addr + IDX_W'(1);
    end else begin
      addr <= head;
    end
    live1 <= (CNT_W'(k) < fill);
    k1    <= k;
    k2    <= k1;
  end

  always_comb begin
    state_next     = state;
    feed_ready     = 1'b0;
    issue          = 1'b0;
    dly_we         = 1'b0;
    wt_we          = v2 && upd_pass;
    wt_waddr       = k2;
    ctl            = '0;
    ctl.data_valid = v1;
    ctl.sample_live = live1;
    ctl.acc_add    = v2 && !upd_pass;

    case (state)
      lafir_pkg::ST_CLEAR: begin
        wt_we        = 1'b1;
        wt_waddr     = k;
        ctl.wt_clear = 1'b1;
        if (k == LAST) begin
          state_next = lafir_pkg::ST_IDLE;
        end
      end
      lafir_pkg::ST_IDLE: begin
        feed_ready    = 1'b1;
        dly_we        = feed_valid;
        ctl.load_item = feed_valid;
        if (feed_valid) begin
          state_next = lafir_pkg::ST_FILTER;
        end
      end
      lafir_pkg::ST_FILTER: begin
        issue = 1'b1;
        if (k == LAST) begin
          state_next = lafir_pkg::ST_FDRAIN;
        end
      end
      lafir_pkg::ST_FDRAIN: begin
        if (!v1 && !v2) begin
          state_next = lafir_pkg::ST_ROUND;
        end
      end
      lafir_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        state_next   = lafir_pkg::ST_GAIN;
      end
      lafir_pkg::ST_GAIN: begin
        ctl.gain_en = 1'b1;
        state_next  = lafir_pkg::ST_UPDATE;
      end
      lafir_pkg::ST_UPDATE: begin
        issue = 1'b1;
        if (k == LAST) begin
          state_next = lafir_pkg::ST_UDRAIN;
        end
      end
      lafir_pkg::ST_UDRAIN: begin
        // Interlock: the next item's reads start only once every weight is back.
        if (!v1 && !v2) begin
          state_next = lafir_pkg::ST_DONE;
        end
      end
      lafir_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = lafir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lafir_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

### hw/rtl/lafir_dp.sv
// Arithmetic of the LMS filter: shared multiply-accumulate, rounding and weight update.
`timescale 1ns / 1ps

module lafir_dp #(
  parameter int unsigned TAPS = lafir_pkg::TAPS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lafir_pkg::dp_ctrl_t                    ctl,
  input  logic                                   cfg_we,
  input  logic [lafir_pkg::STEP_W-1:0]           cfg_wdata,
  input  logic signed [lafir_pkg::SAMPLE_W-1:0]  feed_desired,
  input  logic [lafir_pkg::SAMPLE_W-1:0]         rd_sample,
  input  logic [lafir_pkg::WEIGHT_W-1:0]         rd_weight,
  output logic [lafir_pkg::WEIGHT_W-1:0]         wt_wdata,
  output logic signed [lafir_pkg::SAMPLE_W-1:0]  filtered,
  output logic signed [lafir_pkg::ERR_W-1:0]     estimate_error
);

  localparam int unsigned ACC_W = lafir_pkg::PROD_W + $clog2(TAPS);
  localparam int unsigned RB_W  = lafir_pkg::RAW_W + 1;
  localparam int unsigned SW    = lafir_pkg::SAMPLE_W;
  localparam int unsigned WW    = lafir_pkg::WEIGHT_W;

  localparam logic signed [ACC_W-1:0] OUT_BIAS = ACC_W'(1) <<< (lafir_pkg::OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(-32768);
  localparam logic signed [RB_W-1:0]  UPD_BIAS = RB_W'(1) <<< (lafir_pkg::UPD_SHIFT - 1);
  localparam logic signed [lafir_pkg::WSUM_W-1:0] W_MAX =
    lafir_pkg::WSUM_W'(64'sd2147483647);
  localparam logic signed [lafir_pkg::WSUM_W-1:0] W_MIN =
    lafir_pkg::WSUM_W'(-64'sd2147483648);

  logic [lafir_pkg::STEP_W-1:0]              step_size;
  logic signed [SW-1:0]                      desired;
  logic signed [SW-1:0]                      s_eff;
  logic signed [lafir_pkg::PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]                   acc;
  logic signed [ACC_W-1:0]                   acc_rnd;
  logic signed [ACC_W-1:0]                   acc_sh;
  logic signed [SW-1:0]                      y_sat;
  logic signed [SW-1:0]                      y;
  logic signed [lafir_pkg::ERR_W-1:0]        err;
  logic signed [lafir_pkg::MUERR_W-1:0]      mu_err;
  logic signed [lafir_pkg::GAIN_W-1:0]       gain;
  logic signed [lafir_pkg::RAW_W-1:0]        raw;
  logic signed [WW-1:0]                      wreg;
  logic signed [RB_W-1:0]                    raw_rnd;
  logic signed [RB_W-1:0]                    delta;
  logic signed [lafir_pkg::WSUM_W-1:0]       wsum;
  logic signed [WW-1:0]                      w_sat;

  // Taps that have not been filled since the last clear read as zero.
  assign s_eff = ctl.sample_live ? $signed(rd_sample) : '0;

  // Output rounding: half up, then saturate to Q1.15.
  assign acc_rnd = acc + OUT_BIAS;
  assign acc_sh  = acc_rnd >>> lafir_pkg::OUT_SHIFT;
  always_comb begin
    if (acc_sh > Y_MAX) begin
      y_sat = SW'(Y_MAX);
    end else if (acc_sh < Y_MIN) begin
      y_sat = SW'(Y_MIN);
    end else begin
      y_sat = acc_sh[SW-1:0];
    end
  end

  assign mu_err = $signed({1'b0, step_size}) * err;

  // Weight update: round the raw step to Q4.28, add, saturate to 32 bits.
  assign raw_rnd = RB_W'(raw) + UPD_BIAS;
  assign delta   = raw_rnd >>> lafir_pkg::UPD_SHIFT;
  assign wsum    = delta[lafir_pkg::WSUM_W-1:0] + lafir_pkg::WSUM_W'(wreg);
  always_comb begin
    if (wsum > W_MAX) begin
      w_sat = WW'(W_MAX);
    end else if (wsum < W_MIN) begin
      w_sat = WW'(W_MIN);
    end else begin
      w_sat = wsum[WW-1:0];
    end
  end

  assign wt_wdata = ctl.wt_clear ? '0 : w_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= lafir_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      desired <= feed_desired;
    end
    if (ctl.data_valid) begin
      prod <= $signed(rd_weight) * s_eff;
      raw  <= gain * s_eff;
      wreg <= $signed(rd_weight);
    end
    if (ctl.load_item) begin
      acc <= '0;
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (ctl.round_en) begin
      y   <= y_sat;
      err <= lafir_pkg::ERR_W'(desired) - lafir_pkg::ERR_W'(y_sat);
    end
    if (ctl.gain_en) begin
      gain <= {mu_err, 1'b0};
    end
    if (ctl.out_load) begin
      filtered       <= y;
      estimate_error <= err;
    end
  end

endmodule

### hw/rtl/lafir_checker.sv
// Port checker for the LMS adaptive FIR filter unit, bound to the top level.
`timescale 1ns / 1ps
`include "lms_adaptive_fir_filter_unit_macros.svh"

module lafir_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  feed_valid,
  input logic                                  feed_ready,
  input logic                                  result_valid,
  input logic                                  result_ready,
  input logic signed [lafir_pkg::SAMPLE_W-1:0] result_filtered,
  input logic signed [lafir_pkg::ERR_W-1:0]    result_estimate_error
);

  // Reset starts the weight clearing pass with nothing to deliver.
  `LAFIR_ASSERT(a_reset_quiet, clk, rst |=> !feed_ready && !result_valid, "busy after reset")

  // One item at a time: the unit is busy right after taking a word.
  `LAFIR_ASSERT_RST(a_busy_after_accept, clk, rst, feed_valid && feed_ready |=> !feed_ready, "word taken while busy")

  `LAFIR_ASSERT_RST(a_result_held, clk, rst, result_valid && !result_ready |=> result_valid, "result dropped")

  `LAFIR_ASSERT_RST(a_result_stable, clk, rst, result_valid && !result_ready |=> $stable(result_filtered) && $stable(result_estimate_error), "result changed while stalled")

endmodule

bind lms_adaptive_fir_filter_unit lafir_checker u_lafir_checker (
  .clk                   (clk),
  .rst                   (rst),
  .feed_valid            (feed.valid),
  .feed_ready            (feed.ready),
  .result_valid          (result.valid),
  .result_ready          (result.ready),
  .result_filtered       (result.filtered),
  .result_estimate_error (result.estimate_error)
);
